FILE: rtl/core/rti_pkg.sv
`default_nettype none
// Shared types and constants of the risk table interpolator.
package rti_pkg;

  // Default table capacities.
  localparam int MAX_ROWS_DEF = 128;
  localparam int MAX_COLS_DEF = 16;

  // Input word kinds.
  typedef enum logic [1:0] {
    KIND_ROW_KEY = 2'd0,
    KIND_BREAK   = 2'd1,
    KIND_CELL    = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_NO_AGE = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1
  } cfg_idx_t;

  // One input word.
  typedef struct packed {
    logic [1:0]         kind;
    logic [6:0]         row_slot;
    logic [3:0]         col_slot;
    logic [7:0]         age;
    logic signed [31:0] point;
    logic signed [31:0] cell_req;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic signed [31:0] risk;
    logic [1:0]         status;
  } out_word_t;

  // Query sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW,
    S_BP0,
    S_BPL,
    S_BPH,
    S_SCAN,
    S_CELL,
    S_CELLW,
    S_CELLA,
    S_CELLB,
    S_CELLC,
    S_DIVW,
    S_DONE
  } bk_state_t;

  // Multiply-divide unit states.
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/risk_table_interpolator.sv
`default_nettype none
// Risk table interpolator.
// Words enter on the in_ channel (valid/ready). Kinds 0..2 load a row key, a
// column breakpoint or a table cell; loads give no result. Kind 3 is a query
// and gives exactly one result word on the out_ channel: a Q16.16 risk value
// and a status (ok, table empty, age not found).
// The cfg_ channel writes rows_in_use (index 0) and cols_in_use (index 1); it
// is always ready and should be used while no query is in flight.
// A two-word queue sits between the input side and the query sequencer, and a
// result register sits at the output, so input is taken while a result waits.
// Sequencing: a load is taken in the idle state. A query on an empty table goes
// straight to the done state; otherwise the sequencer searches the rows for the
// age (going to done if none matches), checks the low and high breakpoints for
// a clamp, scans the breakpoints, and reads one cell or, to interpolate, two
// cells and runs the serial multiply-divide unit (32 product steps, then 65
// quotient steps). The sequencer takes no new word from the queue until the
// result of the last query has gone to the result register.
// Reset clears the counts, the queue and the out_valid flag; table contents
// stay undefined until loaded. A stalled receiver holds the result register,
// and the sequencer then waits, after which the queue fills and in_ready drops.
module risk_table_interpolator import rti_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_word,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] rows_in_use_r, rows_in_use_nxt;
  logic [4:0] cols_in_use_r, cols_in_use_nxt;
  logic       q_valid;
  logic       q_pop;
  in_word_t   q_word;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    rows_in_use_nxt = rows_in_use_r;
    cols_in_use_nxt = cols_in_use_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS: rows_in_use_nxt = cfg_data;
        CFG_COLS: cols_in_use_nxt = cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= '0;
      cols_in_use_r <= '0;
    end else begin
      rows_in_use_r <= rows_in_use_nxt;
      cols_in_use_r <= cols_in_use_nxt;
    end
  end

  rti_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  rti_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .rows_in_use (rows_in_use_r),
    .cols_in_use (cols_in_use_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule
`default_nettype wire

FILE: rtl/core/rti_front.sv
`default_nettype none
// Front end: accepts words, drops loads aimed past the table, and queues the rest.
module rti_front import rti_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  output logic          q_valid,
  output in_word_t      q_word,
  input  wire logic     q_pop
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  in_word_t   fifo_r [2];
  logic       keep;
  logic       push;
  logic       pop;
  logic       row_ok;
  logic       col_ok;

  // A load whose slot lies outside the table has no effect and is not queued.
  assign row_ok = 32'(in_word.row_slot) < MAX_ROWS;
  assign col_ok = 32'(in_word.col_slot) < MAX_COLS;

  always_comb begin
    case (kind_t'(in_word.kind))
      KIND_ROW_KEY: keep = row_ok;
      KIND_BREAK:   keep = col_ok;
      KIND_CELL:    keep = row_ok && col_ok;
      default:      keep = 1'b1;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = fifo_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_word;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rti_muldiv.sv
`default_nettype none
// Serial unit: floor(mag * dp / dx), one product bit then one quotient bit a cycle.
module rti_muldiv import rti_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [32:0] mag,
  input  wire logic [31:0] dp,
  input  wire logic [31:0] dx,
  output logic             done,
  output logic [32:0]      quot
);

  md_state_t   state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [64:0] acc_r, acc_nxt;
  logic [64:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] d_r, d_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem_r, acc_r[64]};
  assign ge    = trial >= {1'b0, d_r};
  assign done  = (state_r == MD_DONE);
  assign quot  = acc_r[32:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MD_IDLE: if (start) state_nxt = MD_MUL;
      MD_MUL:  if (cnt_r == 7'd31) state_nxt = MD_DIV;
      MD_DIV:  if (cnt_r == 7'd64) state_nxt = MD_DONE;
      MD_DONE: state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  // Shift-add product, then restoring division of the product.
  always_comb begin
    cnt_nxt = cnt_r + 7'd1;
    acc_nxt = acc_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    d_nxt   = d_r;
    rem_nxt = rem_r;
    case (state_r)
      MD_IDLE: begin
        cnt_nxt = '0;
        acc_nxt = '0;
        a_nxt   = {32'd0, mag};
        b_nxt   = dp;
        d_nxt   = dx;
        rem_nxt = '0;
      end
      MD_MUL: begin
        if (b_r[0]) begin
          acc_nxt = acc_r + a_r;
        end
        a_nxt = {a_r[63:0], 1'b0};
        b_nxt = {1'b0, b_r[31:1]};
        if (cnt_r == 7'd31) begin
          cnt_nxt = '0;
        end
      end
      MD_DIV: begin
        rem_nxt = ge ? 32'(trial - {1'b0, d_r}) : trial[31:0];
        acc_nxt = {acc_r[63:0], ge};
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/core/rti_back.sv
`default_nettype none
// Back end: table memories, query sequencer and result register.
module rti_back import rti_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire in_word_t q_word,
  output logic          q_pop,
  input  wire logic [7:0] rows_in_use,
  input  wire logic [4:0] cols_in_use,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_word
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

  bk_state_t state_r, state_nxt;

  logic [7:0]         age_r, age_nxt;
  logic signed [31:0] point_r, point_nxt;
  logic [7:0]         idx_r, idx_nxt;
  logic [7:0]         cmp_idx_r, cmp_idx_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic signed [31:0] x2_r, x2_nxt;
  logic signed [31:0] y1_r, y1_nxt;
  logic               neg_r, neg_nxt;
  out_word_t          pend_r, pend_nxt;
  out_word_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [7:0]         keys_m  [MAX_ROWS];
  logic signed [31:0] bps_m   [MAX_COLS];
  logic signed [31:0] cells_m [MAX_ROWS * MAX_COLS];
  logic [7:0]         key_q;
  logic signed [31:0] bp_q;
  logic signed [31:0] cell_q;

  logic [7:0]    nr;
  logic [4:0]    nc;
  logic          take;
  logic          is_query;
  logic          empty;
  logic          row_hit;
  logic          row_last;
  logic          row_issue;
  logic          scan_stop;
  logic [RW-1:0] key_ra;
  logic [CW-1:0] bp_ra;
  logic [AW-1:0] cell_ra;
  logic [AW-1:0] row_base;
  logic [AW-1:0] cell_wa;

  logic               md_start;
  logic               md_done;
  logic [32:0]        md_quot;
  logic signed [32:0] dy;
  logic [32:0]        mag;
  logic signed [32:0] dp_w;
  logic signed [32:0] dx_w;
  logic signed [34:0] s_w;
  logic signed [34:0] sum_w;
  logic signed [31:0] sat_w;

  // Counts are limited to the table capacity.
  assign nr = (32'(rows_in_use) < MAX_ROWS) ? rows_in_use : 8'(MAX_ROWS);
  assign nc = (32'(cols_in_use) < MAX_COLS) ? cols_in_use : 5'(MAX_COLS);

  assign take     = (state_r == S_IDLE) && q_valid;
  assign q_pop    = take;
  assign is_query = (kind_t'(q_word.kind) == KIND_QUERY);
  assign empty    = (nr == 8'd0) || (nc == 5'd0);

  // Row search compares the key read in the previous cycle.
  assign row_hit   = cmp_v_r && (key_q == age_r);
  assign row_last  = cmp_v_r && (cmp_idx_r == nr - 8'd1);
  assign row_issue = idx_r < nr;
  assign scan_stop = (bp_q >= point_r) || (idx_r == {3'd0, nc} - 8'd1);

  // Memory addresses.
  assign key_ra   = RW'(idx_r);
  assign row_base = AW'(row_r) * AW'(MAX_COLS);
  assign cell_wa  = AW'(q_word.row_slot) * AW'(MAX_COLS) + AW'(q_word.col_slot);

  always_comb begin
    case (state_r)
      S_BP0:   bp_ra = '0;
      S_BPL:   bp_ra = CW'(nc - 5'd1);
      S_BPH:   bp_ra = CW'(1);
      S_SCAN:  bp_ra = CW'(idx_r + 8'd1);
      default: bp_ra = '0;
    endcase
  end

  always_comb begin
    case (state_r)
      S_CELLA: cell_ra = row_base + AW'(col_r) - AW'(1);
      default: cell_ra = row_base + AW'(col_r);
    endcase
  end

  // Table writes from load words and registered reads.
  always_ff @(posedge clk) begin
    if (take && kind_t'(q_word.kind) == KIND_ROW_KEY) begin
      keys_m[RW'(q_word.row_slot)] <= q_word.age;
    end
    if (take && kind_t'(q_word.kind) == KIND_BREAK) begin
      bps_m[CW'(q_word.col_slot)] <= q_word.point;
    end
    if (take && kind_t'(q_word.kind) == KIND_CELL) begin
      cells_m[cell_wa] <= q_word.cell_req;
    end
    key_q  <= keys_m[key_ra];
    bp_q   <= bps_m[bp_ra];
    cell_q <= cells_m[cell_ra];
  end

  // Interpolation operands: the span between neighbors and the cell difference.
  assign dy       = {cell_q[31], cell_q} - {y1_r[31], y1_r};
  assign mag      = dy[32] ? 33'(-dy) : 33'(dy);
  assign dp_w     = {point_r[31], point_r} - {prev_r[31], prev_r};
  assign dx_w     = {x2_r[31], x2_r} - {prev_r[31], prev_r};
  assign md_start = (state_r == S_CELLC);

  rti_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .mag   (mag),
    .dp    (dp_w[31:0]),
    .dx    (dx_w[31:0]),
    .done  (md_done),
    .quot  (md_quot)
  );

  // Apply the sign, add the low cell and saturate.
  always_comb begin
    s_w   = neg_r ? -$signed({2'b00, md_quot}) : $signed({2'b00, md_quot});
    sum_w = {{3{y1_r[31]}}, y1_r} + s_w;
    if (sum_w > 35'sd2147483647) begin
      sat_w = 32'sh7fffffff;
    end else if (sum_w < -35'sd2147483648) begin
      sat_w = 32'sh80000000;
    end else begin
      sat_w = sum_w[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take && is_query) begin
          state_nxt = empty ? S_DONE : S_ROW;
        end
      end
      S_ROW: begin
        if (row_hit) begin
          state_nxt = S_BP0;
        end else if (row_last) begin
          state_nxt = S_DONE;
        end
      end
      S_BP0:   state_nxt = S_BPL;
      S_BPL:   state_nxt = (point_r <= bp_q) ? S_CELL : S_BPH;
      S_BPH:   state_nxt = (point_r >= bp_q) ? S_CELL : S_SCAN;
      S_SCAN: begin
        if (scan_stop) begin
          state_nxt = (bp_q == point_r) ? S_CELL : S_CELLA;
        end
      end
      S_CELL:  state_nxt = S_CELLW;
      S_CELLW: state_nxt = S_DONE;
      S_CELLA: state_nxt = S_CELLB;
      S_CELLB: state_nxt = S_CELLC;
      S_CELLC: state_nxt = S_DIVW;
      S_DIVW:  if (md_done) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result register updates.
  always_comb begin
    age_nxt       = age_r;
    point_nxt     = point_r;
    idx_nxt       = idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_v_nxt     = 1'b0;
    row_nxt       = row_r;
    col_nxt       = col_r;
    prev_nxt      = prev_r;
    x2_nxt        = x2_r;
    y1_nxt        = y1_r;
    neg_nxt       = neg_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        age_nxt         = q_word.age;
        point_nxt       = q_word.point;
        idx_nxt         = '0;
        pend_nxt.risk   = '0;
        pend_nxt.status = ST_EMPTY;
      end
      S_ROW: begin
        cmp_v_nxt   = row_issue && !row_hit;
        cmp_idx_nxt = idx_r;
        if (row_issue) begin
          idx_nxt = idx_r + 8'd1;
        end
        if (row_hit) begin
          row_nxt = RW'(cmp_idx_r);
        end
        pend_nxt.status = ST_NO_AGE;
      end
      S_BPL: begin
        col_nxt  = '0;
        prev_nxt = bp_q;
      end
      S_BPH: begin
        col_nxt = CW'(nc - 5'd1);
        idx_nxt = 8'd1;
      end
      S_SCAN: begin
        col_nxt = CW'(idx_r);
        x2_nxt  = bp_q;
        if (!scan_stop) begin
          prev_nxt = bp_q;
          idx_nxt  = idx_r + 8'd1;
        end
      end
      S_CELLW: begin
        pend_nxt.risk   = cell_q;
        pend_nxt.status = ST_OK;
      end
      S_CELLB: y1_nxt = cell_q;
      S_CELLC: neg_nxt = dy[32];
      S_DIVW: begin
        pend_nxt.risk   = sat_w;
        pend_nxt.status = ST_OK;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    age_r     <= age_nxt;
    point_r   <= point_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    prev_r    <= prev_nxt;
    x2_r      <= x2_nxt;
    y1_r      <= y1_nxt;
    neg_r     <= neg_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // A result that is not ok carries a zero risk value.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status == ST_OK || out_r.risk == 32'sd0))
    else $error("non-ok result with nonzero risk");

  // The queue is only drained while the sequencer is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && q_valid))
    else $error("queue popped outside idle");

  // A matched row lies inside the loaded rows.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW && row_hit) |-> cmp_idx_r < nr)
    else $error("row match beyond loaded rows");

  // The breakpoint scan stays strictly inside the loaded columns.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (idx_r != 8'd0 && idx_r < {3'd0, nc}))
    else $error("breakpoint scan out of range");

endmodule
`default_nettype wire

FILE: test/testbench.sv
module testbench;
  import rti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  risk_table_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the table and the two counts.
  logic [7:0] rows_cfg;
  logic [4:0] cols_cfg;
  logic [7:0] row_key_tbl [0:127];
  int         bp_tbl [0:15];
  int         cell_tbl [0:2047];
  bit         key_loaded [0:127];
  bit         bp_loaded [0:15];
  bit         cell_loaded [0:2047];

  out_word_t  risk_expected [$];
  int         errors = 0;
  int         rx_hold = 0;
  int         rx_wait;
  bit         no_idle = 1'b0;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int rows_eff();
    return (rows_cfg > 128) ? 128 : int'(rows_cfg);
  endfunction

  function automatic int cols_eff();
    return (cols_cfg > 16) ? 16 : int'(cols_cfg);
  endfunction

  // Expected result of a query against the shadow table.
  function automatic out_word_t lookup_risk(in_word_t w);
    int nr, nc, i, row;
    bit found, neg;
    longint p, x1, x2, y1, y2, dy, s, v;
    longint unsigned dx, dp, mag, qa, ra, q;
    out_word_t r;
    nr = rows_eff();
    nc = cols_eff();
    r.risk = 0;
    r.status = ST_OK;
    found = 1'b0;
    row = 0;
    if (nr == 0 || nc == 0) begin
      r.status = ST_EMPTY;
    end else begin
      for (i = 0; i < nr && !found; i++) begin
        if (row_key_tbl[i] == w.age) begin
          row = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = ST_NO_AGE;
      end else begin
        p = $signed(w.point);
        if (p <= bp_tbl[0]) begin
          r.risk = cell_tbl[row*16];
        end else if (p >= bp_tbl[nc-1]) begin
          r.risk = cell_tbl[row*16 + nc - 1];
        end else begin
          i = 1;
          while (i < nc - 1 && bp_tbl[i] < p) i++;
          if (bp_tbl[i] == p) begin
            r.risk = cell_tbl[row*16 + i];
          end else begin
            x1 = bp_tbl[i-1];
            x2 = bp_tbl[i];
            y1 = cell_tbl[row*16 + i - 1];
            y2 = cell_tbl[row*16 + i];
            dx = x2 - x1;
            dp = p - x1;
            dy = y2 - y1;
            neg = dy < 0;
            mag = neg ? -dy : dy;
            qa = mag / dx;
            ra = mag % dx;
            q = qa * dp + (ra * dp) / dx;
            s = neg ? -longint'(q) : longint'(q);
            v = y1 + s;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.risk = v[31:0];
          end
        end
      end
    end
    return r;
  endfunction

  // Replaces a query by the first missing load: an unloaded key or breakpoint in use, or cell of its row.
  function automatic in_word_t fill_missing(in_word_t w);
    int nr, nc, i, row;
    bit found;
    in_word_t f;
    nr = rows_eff();
    nc = cols_eff();
    f = w;
    if (nr == 0 || nc == 0) return w;
    for (i = 0; i < nr; i++) begin
      if (!key_loaded[i]) begin
        f.kind = KIND_ROW_KEY;
        f.row_slot = 7'(i);
        return f;
      end
    end
    for (i = 0; i < nc; i++) begin
      if (!bp_loaded[i]) begin
        f.kind = KIND_BREAK;
        f.col_slot = 4'(i);
        return f;
      end
    end
    found = 1'b0;
    row = 0;
    for (i = 0; i < nr && !found; i++) begin
      if (row_key_tbl[i] == w.age) begin
        row = i;
        found = 1'b1;
      end
    end
    if (found) begin
      for (i = 0; i < nc; i++) begin
        if (!cell_loaded[row*16 + i]) begin
          f.kind = KIND_CELL;
          f.row_slot = 7'(row);
          f.col_slot = 4'(i);
          return f;
        end
      end
    end
    return w;
  endfunction

  // Updates the shadow table for an accepted word and queues any result.
  task automatic track_word(in_word_t w);
    case (w.kind)
      KIND_ROW_KEY: begin
        row_key_tbl[w.row_slot] = w.age;
        key_loaded[w.row_slot] = 1'b1;
      end
      KIND_BREAK: begin
        bp_tbl[w.col_slot] = w.point;
        bp_loaded[w.col_slot] = 1'b1;
      end
      KIND_CELL: begin
        cell_tbl[w.row_slot*16 + w.col_slot] = w.cell_req;
        cell_loaded[w.row_slot*16 + w.col_slot] = 1'b1;
      end
      default: risk_expected.push_back(lookup_risk(w));
    endcase
  endtask

  // Sends one word, after a random gap unless idling is off.
  task automatic send_word(in_word_t w);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    track_word(w);
  endtask

  function automatic in_word_t rand_word(logic [1:0] kind);
    in_word_t w;
    w.kind = kind;
    w.row_slot = 7'($urandom);
    w.col_slot = 4'($urandom);
    w.age = 8'($urandom);
    w.point = $urandom;
    w.cell_req = $urandom;
    return w;
  endfunction

  task automatic load_key(int slot, logic [7:0] age);
    in_word_t w;
    w = rand_word(KIND_ROW_KEY);
    w.row_slot = 7'(slot);
    w.age = age;
    send_word(w);
  endtask

  task automatic load_bp(int slot, logic [31:0] point);
    in_word_t w;
    w = rand_word(KIND_BREAK);
    w.col_slot = 4'(slot);
    w.point = point;
    send_word(w);
  endtask

  task automatic load_cell(int row, int col, logic [31:0] value);
    in_word_t w;
    w = rand_word(KIND_CELL);
    w.row_slot = 7'(row);
    w.col_slot = 4'(col);
    w.cell_req = value;
    send_word(w);
  endtask

  task automatic query(logic [7:0] age, logic [31:0] point);
    in_word_t w;
    w = rand_word(KIND_QUERY);
    w.age = age;
    w.point = point;
    send_word(fill_missing(w));
  endtask

  // Waits until every result is in and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (risk_expected.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Writes both counts while the block is idle.
  task automatic set_counts(logic [7:0] rows, logic [4:0] cols);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data <= rows;
    do @(posedge clk); while (!cfg_ready);
    rows_cfg = rows;
    cfg_index <= CFG_COLS;
    cfg_data <= {3'b000, cols};
    do @(posedge clk); while (!cfg_ready);
    cols_cfg = cols;
    cfg_valid <= 1'b0;
  endtask

  // Receiver with random stalls and an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) rx_wait <= pick_gap();
    end
  end

  // Result checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (risk_expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result risk=%h status=%0d",
                                   out_word.risk, out_word.status);
      end else begin
        e = risk_expected.pop_front();
        if (out_word.risk !== e.risk || out_word.status !== e.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected risk=%h status=%0d, got risk=%h status=%0d",
                     e.risk, e.status, out_word.risk, out_word.status);
        end
      end
    end
  end

  // Queries with one or both counts at zero.
  task automatic test_empty_table();
    query(8'd0, 32'h0000_0000);
    query(8'hFF, 32'h7FFF_FFFF);
    set_counts(8'd1, 5'd0);
    load_key(0, 8'd9);
    query(8'd9, 32'h8000_0000);
    set_counts(8'd0, 5'd1);
    load_bp(0, 32'h0);
    query(8'd9, 32'h0);
  endtask

  // Clamps, exact hits, interpolation, duplicates, unknown age, one column.
  task automatic test_directed_lookup();
    int c;
    load_key(0, 8'd40);
    load_key(1, 8'd41);
    load_key(2, 8'd40);
    load_bp(0, 32'h8000_0000);
    load_bp(1, 32'h0000_0000);
    load_bp(2, 32'h0002_0000);
    load_bp(3, 32'h7FFF_FFFF);
    load_cell(0, 0, 32'h7FFF_FFFF);
    load_cell(0, 1, 32'h8000_0000);
    load_cell(0, 2, 32'h0001_0000);
    load_cell(0, 3, 32'hFFFF_FFFB);
    for (c = 0; c < 4; c++) load_cell(1, c, 32'h0003_0000 * c);
    set_counts(8'd3, 5'd4);
    query(8'd40, 32'h8000_0000);
    query(8'd40, 32'h7FFF_FFFF);
    query(8'd40, 32'h0000_0000);
    query(8'd40, 32'h0001_0000);
    query(8'd40, 32'hFFFF_FFFF);
    query(8'd40, 32'h0002_0001);
    query(8'd41, 32'h0000_8000);
    query(8'd99, 32'h0000_0000);
    set_counts(8'd3, 5'd1);
    query(8'd41, 32'h8000_0000);
    query(8'd41, 32'h7FFF_FFFF);
  endtask

  // Long receiver hold-off while words keep coming, so the input stalls.
  task automatic test_backpressure();
    int n;
    drain();
    no_idle = 1'b1;
    rx_hold = 600;
    for (n = 0; n < 20; n++) query(($urandom_range(0, 1) != 0) ? 8'd40 : 8'd41, $urandom);
    no_idle = 1'b0;
  endtask

  // Random phases over a range of counts, including the extremes.
  task automatic test_random();
    int ph_rows [10] = '{2, 5, 1, 255, 4, 0, 6, 3, 200, 7};
    int ph_cols [10] = '{2, 7, 1, 31, 16, 5, 0, 3, 16, 10};
    int ph, i, nr, nc, mode, k, r;
    longint v;
    logic [31:0] pt;
    in_word_t w;
    for (ph = 0; ph < 10; ph++) begin
      set_counts(8'(ph_rows[ph]), 5'(ph_cols[ph]));
      nr = rows_eff();
      nc = cols_eff();
      no_idle = (ph == 2);
      mode = $urandom_range(0, 3);
      for (i = 0; i < nr; i++)
        load_key(i, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)));
      v = -longint'($urandom_range(0, 1 << 20));
      for (i = 0; i < nc; i++) begin
        case (mode)
          0: pt = (nc == 1) ? 32'h0 : 32'(-64'sd2147483648 + (longint'(i) * 64'sd4294967295) / (nc - 1));
          3: pt = $urandom;
          default: begin
            pt = v[31:0];
            v = v + $urandom_range(1, 1 << 18);
          end
        endcase
        load_bp(i, pt);
      end
      for (r = 0; r < nr && r < 3; r++)
        for (i = 0; i < nc; i++) load_cell(r, i, $urandom);
      for (i = 0; i < 80; i++) begin
        if ($urandom_range(0, 9) < 3) begin
          w = rand_word(2'($urandom_range(0, 2)));
          if (w.kind == KIND_BREAK && $urandom_range(0, 2) != 0) w.kind = KIND_CELL;
          send_word(w);
        end else begin
          k = (nc > 0) ? $urandom_range(0, nc - 1) : 0;
          case ($urandom_range(0, 5))
            0: pt = bp_tbl[k];
            1: pt = bp_tbl[k] + 1;
            2: pt = bp_tbl[k] - 1;
            3: pt = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: pt = (k < nc - 1) ?
                    32'(longint'(bp_tbl[k]) + (longint'(bp_tbl[k+1]) - bp_tbl[k]) / 2) : $urandom;
            default: pt = $urandom;
          endcase
          if (nr > 0 && $urandom_range(0, 3) != 0)
            query(row_key_tbl[$urandom_range(0, nr - 1)], pt);
          else
            query(8'($urandom), pt);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROWS;
    cfg_data = '0;
    rows_cfg = '0;
    cols_cfg = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_directed_lookup();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && risk_expected.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rti_pkg.sv
rtl/core/rti_front.sv
rtl/core/rti_muldiv.sv
rtl/core/rti_back.sv
rtl/core/risk_table_interpolator.sv
test/testbench.sv
